FILE: design/u2u_pkg.sv
// shared types and constants for the utf-8 to utf-16 string packer
// no dependencies; imported by the decoder, the result queue and the top level
package u2u_pkg;

    localparam int BYTE_W      = 8;
    localparam int UNIT_W      = 16;
    localparam int CNT_W       = 8;
    localparam int MAX_CHARS_D = 254;

    // result queue: one byte can push up to three units
    localparam int PUSH_MAX = 3;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);
    localparam int PUSH_W   = $clog2(PUSH_MAX + 1);

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_TERM = 2'd1,
        KIND_LEN  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        kind_t             unit_kind;
        logic              last_unit;
    } res_t;

    // units produced by one byte, in delivery order from slot 0
    typedef struct packed {
        logic [PUSH_W-1:0]       n;
        res_t [PUSH_MAX-1:0]     unit;
    } push_t;

endpackage

FILE: design/u2u_decode.sv
// input register, running string state and per-byte decode
// depends on u2u_pkg; hands a bundle of up to three units to the result queue
module u2u_decode
    import u2u_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_string,
    input  logic              room,
    output push_t             push
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              eos_reg;
    logic              load;
    logic              fire;

    logic [UNIT_W-1:0] pv_reg;
    logic [UNIT_W-1:0] pv_next;
    logic [1:0]        bp_reg;
    logic [1:0]        bp_next;
    logic [CNT_W-1:0]  cc_reg;
    logic [CNT_W-1:0]  cc_next;

    logic              char_valid;
    logic [UNIT_W-1:0] char_val;
    logic [UNIT_W-1:0] shifted;
    logic [CNT_W-1:0]  cc_after;
    logic              finish;
    res_t              char_unit;
    res_t              term_unit;
    res_t              len_unit;

    assign fire       = valid_reg && room;
    assign byte_stall = valid_reg && !room;
    assign load       = byte_valid && !byte_stall;
    assign valid_next = load ? 1'b1 : (fire ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pv_reg    <= '0;
            bp_reg    <= '0;
            cc_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pv_reg    <= pv_next;
            bp_reg    <= bp_next;
            cc_reg    <= cc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
            eos_reg  <= end_of_string;
        end
    end

    assign shifted = {pv_reg[UNIT_W-7:0], byte_reg[5:0]};
    assign finish  = eos_reg || (byte_reg == '0);

    always_comb
    begin
        pv_next    = pv_reg;
        bp_next    = bp_reg;
        cc_next    = cc_reg;
        char_valid = 1'b0;
        char_val   = '0;
        push       = '0;

        if (fire && (byte_reg != '0))
        begin
            if (bp_reg != 2'd0)
            begin
                pv_next = shifted;
                bp_next = bp_reg - 2'd1;
                if (bp_reg == 2'd1)
                begin
                    char_valid = 1'b1;
                    char_val   = shifted;
                    pv_next    = '0;
                end
            end
            else if (cc_reg < CNT_W'(MAX_CHARS))
            begin
                if (!byte_reg[7])
                begin
                    char_valid = 1'b1;
                    char_val   = {{(UNIT_W-BYTE_W){1'b0}}, byte_reg};
                end
                else if (byte_reg[7:5] == 3'b110)
                begin
                    pv_next = {{(UNIT_W-5){1'b0}}, byte_reg[4:0]};
                    bp_next = 2'd1;
                end
                else if (byte_reg[7:4] == 4'b1110)
                begin
                    pv_next = {{(UNIT_W-4){1'b0}}, byte_reg[3:0]};
                    bp_next = 2'd2;
                end
                // stray continuation and four-byte leads fall through unchanged
            end
        end

        cc_after = char_valid ? (cc_reg + CNT_W'(1)) : cc_reg;
        if (fire)
        begin
            cc_next = cc_after;
        end

        char_unit = '{code_unit: char_val, unit_kind: KIND_CHAR, last_unit: 1'b0};
        term_unit = '{code_unit: '0, unit_kind: KIND_TERM, last_unit: 1'b0};
        len_unit  = '{code_unit: (cc_after == '0) ? '0
                                 : {{(UNIT_W-CNT_W){1'b0}}, cc_after + CNT_W'(1)},
                      unit_kind: KIND_LEN, last_unit: 1'b1};

        if (fire)
        begin
            if (finish)
            begin
                pv_next = '0;
                bp_next = '0;
                cc_next = '0;
                if (char_valid)
                begin
                    push.n       = PUSH_W'(3);
                    push.unit[0] = char_unit;
                    push.unit[1] = term_unit;
                    push.unit[2] = len_unit;
                end
                else if (cc_after != '0)
                begin
                    push.n       = PUSH_W'(2);
                    push.unit[0] = term_unit;
                    push.unit[1] = len_unit;
                end
                else
                begin
                    push.n       = PUSH_W'(1);
                    push.unit[0] = len_unit;
                end
            end
            else if (char_valid)
            begin
                push.n       = PUSH_W'(1);
                push.unit[0] = char_unit;
            end
        end
    end

endmodule

FILE: design/u2u_queue.sv
// small result queue: takes up to three units a cycle, gives one while unit_stall is low
// depends on u2u_pkg; its head entry is the block's output register
module u2u_queue
    import u2u_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              room,
    output logic              unit_valid,
    input  logic              unit_stall,
    output res_t              head
);

    res_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] head_reg;
    logic [Q_PTR_W-1:0] head_next;
    logic [Q_PTR_W-1:0] tail_reg;
    logic [Q_PTR_W-1:0] tail_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               pop;

    assign unit_valid = (count_reg != '0);
    assign pop        = unit_valid && !unit_stall;
    assign room       = (count_reg <= Q_CNT_W'(Q_DEPTH - PUSH_MAX));
    assign head       = mem_reg[head_reg];

    assign head_next  = pop ? (head_reg + Q_PTR_W'(1)) : head_reg;
    assign tail_next  = tail_reg + Q_PTR_W'(push.n);
    assign count_next = count_reg + Q_CNT_W'(push.n) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PUSH_MAX; i++)
        begin
            if (PUSH_W'(i) < push.n)
            begin
                mem_reg[tail_reg + Q_PTR_W'(i)] <= push.unit[i];
            end
        end
    end

endmodule

FILE: design/utf8_to_utf16_string_packer_top.sv
// top level of the utf-8 to utf-16 string packer
// depends on u2u_pkg, u2u_decode and u2u_queue
//
// usage
//   byte channel: byte_valid/byte_stall with in_byte and end_of_string; one
//   utf-8 byte per item, a zero byte or end_of_string closes the string
//   unit channel: unit_valid/unit_stall with code_unit, unit_kind, last_unit;
//   one item per character completed, then a zero terminator (only when the
//   string kept a character) and a length word flagged by last_unit
//   path: a byte sits in the decoder's input register until the queue has
//   room, then its units are written to the queue, whose head is the output
//   throughput: one byte per cycle while unit_stall is low and each byte
//   gives at most one unit; a closing byte gives up to three units, drained
//   at one per cycle, so the output port sets the rate at string ends
//   the four-entry result queue holds back the byte channel until it has
//   space for three units
//   reset: queue empties, string state clears, no unit is valid
//   receiver stall: the head unit holds; bytes keep flowing until the queue
//   lacks space for a byte's worst case, then byte_stall rises
module utf8_to_utf16_string_packer_top
    import u2u_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_D
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              end_of_string,
    output logic              unit_valid,
    input  logic              unit_stall,
    output logic [UNIT_W-1:0] code_unit,
    output logic [1:0]        unit_kind,
    output logic              last_unit
);

    push_t push;
    logic  room;
    res_t  head;

    u2u_decode #(
        .MAX_CHARS (MAX_CHARS)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .room          (room),
        .push          (push)
    );

    u2u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .head       (head)
    );

    assign code_unit = head.code_unit;
    assign unit_kind = head.unit_kind;
    assign last_unit = head.last_unit;

    // only the length word closes a string
    a_last_is_len: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid |-> (last_unit == (unit_kind == KIND_LEN)))
        else $error("last_unit disagrees with unit_kind");

    // terminator and length word are queued together
    a_term_then_len: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && !unit_stall && (unit_kind == KIND_TERM))
        |=> (unit_valid && (unit_kind == KIND_LEN)))
        else $error("terminator not followed by length word");

    // a nonzero length word is within the character limit
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && (unit_kind == KIND_LEN) && (code_unit != '0))
        |-> ((code_unit >= UNIT_W'(2)) && (code_unit <= UNIT_W'(MAX_CHARS + 1))))
        else $error("length word out of range");

    // a terminator carries a zero code unit
    a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && (unit_kind == KIND_TERM)) |-> (code_unit == '0))
        else $error("terminator not zero");

endmodule
